### sv/low_battery_idle_sleep_guard_macros.svh
// Assertion macros for the low-battery idle sleep guard.
// Included by the top level; no other dependencies.
`ifndef LOW_BATTERY_IDLE_SLEEP_GUARD_MACROS_SVH
`define LOW_BATTERY_IDLE_SLEEP_GUARD_MACROS_SVH
`ifndef ASSERT_OFF
// Condition must hold at every clock edge outside reset.
`define LBG_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// Antecedent in one cycle implies the consequent in the next.
`define LBG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LBG_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define LBG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### sv/lbg_pkg.sv
// Shared types, constants and helper functions for the sleep guard.
// No dependencies; used by every module of the block.
package lbg_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 16;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned VAL_W      = 12;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned CELLS_W    = 4;
  localparam int unsigned ARMCH_W    = 5;
  localparam int unsigned MOVE_W     = 8;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 8;

  // Register indexes of the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CELL_COUNT   = 3'd0,
    REG_ARMING_CH    = 3'd1,
    REG_ARM_THR      = 3'd2,
    REG_MOVE_THR     = 3'd3,
    REG_STILL_TIME   = 3'd4,
    REG_SUSTAIN_TIME = 3'd5,
    REG_MV_PER_CELL  = 3'd6,
    REG_MIN_VALID    = 3'd7
  } cfg_reg_t;

  // Reset values of the registers
  localparam logic [CELLS_W-1:0] CELL_COUNT_RST   = '0;
  localparam logic [ARMCH_W-1:0] ARMING_CH_RST    = '0;
  localparam logic [VAL_W-1:0]   ARM_THR_RST      = 12'd1500;
  localparam logic [MOVE_W-1:0]  MOVE_THR_RST     = 8'd12;
  localparam logic [TIME_W-1:0]  STILL_TIME_RST   = 32'd120000;
  localparam logic [TIME_W-1:0]  SUSTAIN_TIME_RST = 32'd10000;
  localparam logic [MV_W-1:0]    MV_PER_CELL_RST  = 16'd3300;
  localparam logic [MV_W-1:0]    MIN_VALID_RST    = 16'd3000;

  // Input word commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic [CELLS_W-1:0] cell_count;
    logic [ARMCH_W-1:0] arming_channel;
    logic [VAL_W-1:0]   arm_threshold_us;
    logic [MOVE_W-1:0]  move_threshold_us;
    logic [TIME_W-1:0]  still_time_ms;
    logic [TIME_W-1:0]  sustain_time_ms;
    logic [MV_W-1:0]    sleep_mv_per_cell;
    logic [MV_W-1:0]    min_valid_mv;
  } cfg_t;

  typedef struct packed {
    logic               sleep_request;
    logic               is_still;
    logic               is_armed;
    logic [CELLS_W-1:0] cells_used;
    logic               low_pending;
  } tick_res_t;

  // Series cell estimate (mv + 1900) / 3800 clamped to 1..6, as voltage thresholds.
  function automatic logic [CELLS_W-1:0] cell_estimate(input logic [MV_W-1:0] mv);
    logic [CELLS_W-1:0] n;
    n = 4'd1;
    if (mv >= 16'd5700)  n = 4'd2;
    if (mv >= 16'd9500)  n = 4'd3;
    if (mv >= 16'd13300) n = 4'd4;
    if (mv >= 16'd17100) n = 4'd5;
    if (mv >= 16'd20900) n = 4'd6;
    return n;
  endfunction

endpackage

### sv/low_battery_idle_sleep_guard.sv
// Low-battery idle sleep guard: one word a cycle, input register, evaluation, result register.
// A tick word passes from the input register through evaluation into the result register on out_tdata.
// Throughput: one word per cycle; a sample word never stalls, a tick waits only on a full
// result register that is not being taken. Reset (rst_n, synchronous) clears snapshots,
// timers, flags and restores the register defaults; the block is ready right after it.
// Depends on lbg_pkg, lbg_cfg, lbg_chan, lbg_eval and the assertion macro header.
`include "low_battery_idle_sleep_guard_macros.svh"
module low_battery_idle_sleep_guard #(
  parameter int unsigned NUM_CHANNELS = lbg_pkg::NUM_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // channel_index[3:0], channel_value[15:4], now_ms[47:16], battery_mv[63:48],
  // being_flown[64], zero pad [71:65]
  input  logic [lbg_pkg::IN_DATA_W-1:0]     in_tdata,
  // command[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // sleep_request[0], is_still[1], is_armed[2], cells_used[6:3], low_pending[7]
  output logic [lbg_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [lbg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lbg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  lbg_pkg::cfg_t             cfg;
  lbg_pkg::tick_res_t        res;
  logic                      arm_clear;
  logic                      moved;
  logic [lbg_pkg::VAL_W-1:0] arm_value;

  logic                      s1_valid_r;
  logic                      s1_valid_nxt;
  logic                      s1_cmd_r;
  logic [64:0]               s1_data_r;
  logic                      s1_stall;
  logic                      s1_go;
  logic                      in_fire;
  logic                      sample_en;
  logic                      tick_en;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  lbg_pkg::tick_res_t        out_res_r;

  // Input register control: a tick holds only when the result register cannot take it.
  assign s1_stall  = s1_valid_r && (s1_cmd_r == lbg_pkg::CMD_TICK) && out_valid_r && !out_tready;
  assign s1_go     = s1_valid_r && !s1_stall;
  assign in_tready = !s1_stall;
  assign in_fire   = in_tvalid && in_tready;
  assign sample_en = s1_go && (s1_cmd_r == lbg_pkg::CMD_SAMPLE);
  assign tick_en   = s1_go && (s1_cmd_r == lbg_pkg::CMD_TICK);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)    s1_valid_nxt = 1'b1;
    else if (s1_go) s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (tick_en)         out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_tuser;
      s1_data_r <= in_tdata[64:0];
    end
    if (tick_en) out_res_r <= res;
  end

  lbg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .arm_clear (arm_clear)
  );

  lbg_chan #(.NUM_CHANNELS(NUM_CHANNELS)) u_chan (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_en      (sample_en),
    .tick_en        (tick_en),
    .idx            (s1_data_r[3:0]),
    .val            (s1_data_r[15:4]),
    .move_thr       (cfg.move_threshold_us),
    .arming_channel (cfg.arming_channel),
    .arm_clear      (arm_clear),
    .moved          (moved),
    .arm_value      (arm_value)
  );

  lbg_eval #(.NUM_CHANNELS(NUM_CHANNELS)) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_en   (tick_en),
    .now       (s1_data_r[47:16]),
    .mv        (s1_data_r[63:48]),
    .flown     (s1_data_r[64]),
    .moved     (moved),
    .arm_value (arm_value),
    .cfg       (cfg),
    .res       (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.low_pending, out_res_r.cells_used, out_res_r.is_armed,
                       out_res_r.is_still, out_res_r.sleep_request};

  // A request only ever comes from a still, unarmed model with a valid reading.
  `LBG_ASSERT_ALWAYS(a_req_cond, clk, rst_n,
    !(out_valid_r && out_res_r.sleep_request) ||
    (out_res_r.is_still && !out_res_r.is_armed && (out_res_r.cells_used != '0)))
  // A held word in the input register is never lost.
  `LBG_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_stall, s1_valid_r)
  // Every tick consumes the movement flag.
  `LBG_ASSERT_NEXT(a_moved_clr, clk, rst_n, tick_en, !moved)

endmodule

### sv/lbg_cfg.sv
// Configuration register file of the sleep guard.
// Depends on lbg_pkg for register indexes, reset values and the config struct.
module lbg_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lbg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lbg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output lbg_pkg::cfg_t                     cfg,
  output logic                              arm_clear
);

  lbg_pkg::cfg_t cfg_r;
  lbg_pkg::cfg_t cfg_nxt;

  // Decode the write into the addressed field.
  always_comb begin
    cfg_nxt   = cfg_r;
    arm_clear = 1'b0;
    if (cfg_we) begin
      unique case (lbg_pkg::cfg_reg_t'(cfg_addr))
        lbg_pkg::REG_CELL_COUNT:   cfg_nxt.cell_count = cfg_wdata[lbg_pkg::CELLS_W-1:0];
        lbg_pkg::REG_ARMING_CH: begin
          cfg_nxt.arming_channel = cfg_wdata[lbg_pkg::ARMCH_W-1:0];
          arm_clear              = 1'b1;
        end
        lbg_pkg::REG_ARM_THR:      cfg_nxt.arm_threshold_us = cfg_wdata[lbg_pkg::VAL_W-1:0];
        lbg_pkg::REG_MOVE_THR:     cfg_nxt.move_threshold_us = cfg_wdata[lbg_pkg::MOVE_W-1:0];
        lbg_pkg::REG_STILL_TIME:   cfg_nxt.still_time_ms = cfg_wdata[lbg_pkg::TIME_W-1:0];
        lbg_pkg::REG_SUSTAIN_TIME: cfg_nxt.sustain_time_ms = cfg_wdata[lbg_pkg::TIME_W-1:0];
        lbg_pkg::REG_MV_PER_CELL:  cfg_nxt.sleep_mv_per_cell = cfg_wdata[lbg_pkg::MV_W-1:0];
        lbg_pkg::REG_MIN_VALID:    cfg_nxt.min_valid_mv = cfg_wdata[lbg_pkg::MV_W-1:0];
        default: ;
      endcase
    end
  end

  // Registers with their documented reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_count        <= lbg_pkg::CELL_COUNT_RST;
      cfg_r.arming_channel    <= lbg_pkg::ARMING_CH_RST;
      cfg_r.arm_threshold_us  <= lbg_pkg::ARM_THR_RST;
      cfg_r.move_threshold_us <= lbg_pkg::MOVE_THR_RST;
      cfg_r.still_time_ms     <= lbg_pkg::STILL_TIME_RST;
      cfg_r.sustain_time_ms   <= lbg_pkg::SUSTAIN_TIME_RST;
      cfg_r.sleep_mv_per_cell <= lbg_pkg::MV_PER_CELL_RST;
      cfg_r.min_valid_mv      <= lbg_pkg::MIN_VALID_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/lbg_chan.sv
// Channel movement tracker: per-channel snapshots, movement flag and arm channel latch.
// Depends on lbg_pkg for widths.
module lbg_chan #(
  parameter int unsigned NUM_CHANNELS = lbg_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          sample_en,
  input  logic                          tick_en,
  input  logic [lbg_pkg::IDX_W-1:0]     idx,
  input  logic [lbg_pkg::VAL_W-1:0]     val,
  input  logic [lbg_pkg::MOVE_W-1:0]    move_thr,
  input  logic [lbg_pkg::ARMCH_W-1:0]   arming_channel,
  input  logic                          arm_clear,
  output logic                          moved,
  output logic [lbg_pkg::VAL_W-1:0]     arm_value
);

  localparam int unsigned CMP_W = 6;

  logic [lbg_pkg::VAL_W-1:0] snap_r   [NUM_CHANNELS];
  logic [lbg_pkg::VAL_W-1:0] snap_rd;
  logic [lbg_pkg::VAL_W-1:0] diff;
  logic [CMP_W-1:0]          idx_ext;
  logic                      in_range;
  logic                      big_move;
  logic                      arm_hit;
  logic                      moved_r;
  logic                      moved_nxt;
  logic [lbg_pkg::VAL_W-1:0] arm_value_r;
  logic [lbg_pkg::VAL_W-1:0] arm_value_nxt;

  assign idx_ext  = CMP_W'(idx);
  assign in_range = idx_ext < CMP_W'(NUM_CHANNELS);

  // Read the snapshot of the sampled channel.
  always_comb begin
    snap_rd = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (idx_ext == CMP_W'(i)) snap_rd = snap_r[i];
    end
  end

  // Absolute change against the snapshot.
  assign diff     = (val > snap_rd) ? (val - snap_rd) : (snap_rd - val);
  assign big_move = sample_en && in_range &&
                    (diff > lbg_pkg::VAL_W'(move_thr));

  assign arm_hit = sample_en && in_range &&
                   (CMP_W'(arming_channel) == (idx_ext + CMP_W'(1)));

  // Movement flag is set by a large change and cleared by each tick.
  always_comb begin
    moved_nxt = moved_r;
    if (tick_en)       moved_nxt = 1'b0;
    else if (big_move) moved_nxt = 1'b1;
  end

  always_comb begin
    arm_value_nxt = arm_value_r;
    if (arm_clear)    arm_value_nxt = '0;
    else if (arm_hit) arm_value_nxt = val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) snap_r[i] <= '0;
      moved_r     <= 1'b0;
      arm_value_r <= '0;
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (big_move && (idx_ext == CMP_W'(i))) snap_r[i] <= val;
      end
      moved_r     <= moved_nxt;
      arm_value_r <= arm_value_nxt;
    end
  end

  assign moved     = moved_r;
  assign arm_value = arm_value_r;

endmodule

### sv/lbg_eval.sv
// Tick evaluation: stillness, arming, cell count, low-voltage timer and sleep request.
// Depends on lbg_pkg for the config and result structs and the cell estimate.
module lbg_eval #(
  parameter int unsigned NUM_CHANNELS = lbg_pkg::NUM_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tick_en,
  input  logic [lbg_pkg::TIME_W-1:0]   now,
  input  logic [lbg_pkg::MV_W-1:0]     mv,
  input  logic                         flown,
  input  logic                         moved,
  input  logic [lbg_pkg::VAL_W-1:0]    arm_value,
  input  lbg_pkg::cfg_t                cfg,
  output lbg_pkg::tick_res_t           res
);

  localparam int unsigned CMP_W  = 6;
  localparam int unsigned PROD_W = lbg_pkg::MV_W + lbg_pkg::CELLS_W;

  logic [lbg_pkg::TIME_W-1:0]  last_move_r;
  logic [lbg_pkg::TIME_W-1:0]  last_move_nxt;
  logic [lbg_pkg::TIME_W-1:0]  low_since_r;
  logic [lbg_pkg::TIME_W-1:0]  low_since_nxt;
  logic [lbg_pkg::TIME_W-1:0]  lm_eff;
  logic [lbg_pkg::TIME_W-1:0]  ls_eff;
  logic                        still;
  logic                        armed;
  logic                        mv_valid;
  logic [lbg_pkg::CELLS_W-1:0] cells;
  logic [PROD_W-1:0]           limit_mv;
  logic                        low;

  // Last movement time, reloaded after movement or while still zero.
  assign lm_eff = (moved || (last_move_r == '0)) ? now : last_move_r;
  assign still  = (now - lm_eff) >= cfg.still_time_ms;

  assign armed = (cfg.arming_channel != '0) &&
                 (CMP_W'(cfg.arming_channel) <= CMP_W'(NUM_CHANNELS)) &&
                 (arm_value > cfg.arm_threshold_us);

  // Cell count: configured, estimated, or zero for an invalid reading.
  assign mv_valid = mv >= cfg.min_valid_mv;
  always_comb begin
    cells = '0;
    if (mv_valid) begin
      if (cfg.cell_count != '0) cells = cfg.cell_count;
      else                      cells = lbg_pkg::cell_estimate(mv);
    end
  end

  assign limit_mv = PROD_W'(cfg.sleep_mv_per_cell) * PROD_W'(cells);
  assign low      = mv_valid && (PROD_W'(mv) <= limit_mv) && still && !flown && !armed;

  // Low timer starts on the first low tick and is cleared on any tick that is not low.
  assign ls_eff = (low_since_r == '0) ? now : low_since_r;

  always_comb begin
    last_move_nxt = last_move_r;
    low_since_nxt = low_since_r;
    if (tick_en) begin
      last_move_nxt = lm_eff;
      low_since_nxt = low ? ls_eff : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_move_r <= '0;
      low_since_r <= '0;
    end else begin
      last_move_r <= last_move_nxt;
      low_since_r <= low_since_nxt;
    end
  end

  assign res.sleep_request = low && ((now - ls_eff) >= cfg.sustain_time_ms);
  assign res.is_still      = still;
  assign res.is_armed      = armed;
  assign res.cells_used    = cells;
  assign res.low_pending   = low && (ls_eff != '0);

endmodule
